@@ rtl/rmi_pkg.sv @@
`default_nettype none
package rmi_pkg;
  localparam int MaxActions = 8;
  localparam int IdxW = 3;
  localparam int RegW = 48;
  localparam int SumW = 48;
  localparam int ProbW = 17;
  localparam int TotW = 52;
  localparam int NumW = 68;

  localparam logic [1:0] KIND_ADD = 2'd0;
  localparam logic [1:0] KIND_UPDATE = 2'd1;
  localparam logic [1:0] KIND_ACCUM = 2'd2;
  localparam logic [1:0] KIND_READ = 2'd3;

  localparam logic [0:0] CFG_NUM_ACTIONS = 1'd0;
  localparam logic [0:0] CFG_OWN_POSITION = 1'd1;

  function automatic logic [ProbW-1:0] uniform_prob(input logic [3:0] n);
    logic [ProbW-1:0] r;
    begin
      case (n)
        4'd1: r = 17'd65536;
        4'd2: r = 17'd32768;
        4'd3: r = 17'd21845;
        4'd4: r = 17'd16384;
        4'd5: r = 17'd13107;
        4'd6: r = 17'd10922;
        4'd7: r = 17'd9362;
        4'd8: r = 17'd8192;
        default: r = 17'd65536;
      endcase
      return r;
    end
  endfunction
endpackage
`default_nettype wire

@@ rtl/regret_matching_infoset_core.sv @@
`default_nettype none
// Steps: add regret updates one store, accumulate walks every action, and update
// and read average sum the stores, then divide for each action; zero totals skip
// the divider. Throughput: one transaction at a time,
// in_stall high until the item is done; each result waits until taken.
// Synchronous active-low reset clears all stores and the strategy flag and sets
// config to 2 actions, out of position.
module regret_matching_infoset_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_kind,
  input  wire logic [3:0]  in_action_index,
  input  wire logic signed [31:0] in_regret_value,
  input  wire logic        in_use_reach,
  input  wire logic [16:0] in_reach_oop,
  input  wire logic [16:0] in_reach_ip,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_out_action,
  output logic [16:0]      out_avg_probability,
  output logic             out_last,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [3:0]  cfg_data
);
  typedef enum logic [2:0] {
    S_IDLE, S_ADD, S_SUM, S_DIVGO, S_DIVWAIT, S_EMIT, S_ACC
  } state_t;

  state_t state_r;
  logic [3:0] num_actions_r;
  logic own_position_r;
  logic signed [rmi_pkg::RegW-1:0] regret_r [rmi_pkg::MaxActions];
  logic [rmi_pkg::ProbW-1:0] strat_r [rmi_pkg::MaxActions];
  logic [rmi_pkg::SumW-1:0] sum_r [rmi_pkg::MaxActions];
  logic strat_set_r;
  logic [1:0] kind_r;
  logic [3:0] idx_r;
  logic signed [31:0] val_r;
  logic [16:0] reach_r;
  logic weighted_r;
  logic [3:0] n_r;
  logic [rmi_pkg::IdxW-1:0] i_r;
  logic [rmi_pkg::TotW-1:0] tot_r;
  logic div_start, div_done;
  logic [rmi_pkg::ProbW-1:0] div_q;

  logic [3:0] n_eff;
  assign n_eff = (num_actions_r == 4'd0) ? 4'd1 :
                 (num_actions_r > 4'd8) ? 4'd8 : num_actions_r;

  logic last_i;
  assign last_i = ({1'b0, i_r} == n_r - 4'd1);

  logic signed [rmi_pkg::RegW:0] reg_add;
  assign reg_add = {regret_r[idx_r[2:0]][rmi_pkg::RegW-1], regret_r[idx_r[2:0]]}
                 + {{17{val_r[31]}}, val_r};

  logic [rmi_pkg::SumW-1:0] sel_val;
  always_comb begin
    if (kind_r == rmi_pkg::KIND_UPDATE)
      sel_val = regret_r[i_r][rmi_pkg::RegW-1] ? '0 : regret_r[i_r];
    else
      sel_val = sum_r[i_r];
  end

  logic [rmi_pkg::ProbW-1:0] cur_p;
  assign cur_p = strat_set_r ? strat_r[i_r] : rmi_pkg::uniform_prob(n_r);
  logic [33:0] wprod;
  assign wprod = reach_r * cur_p;
  logic [rmi_pkg::ProbW-1:0] acc_add;
  assign acc_add = weighted_r ? wprod[32:16] : cur_p;
  logic [rmi_pkg::SumW:0] sum_add;
  assign sum_add = {1'b0, sum_r[i_r]} + {32'd0, acc_add};

  assign div_start = (state_r == S_DIVGO) && (tot_r != '0);

  rmi_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .numer({sel_val, 20'd0} >> 4), .denom(tot_r),
    .done(div_done), .quot(div_q)
  );

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      num_actions_r <= 4'd2;
      own_position_r <= 1'b0;
      strat_set_r <= 1'b0;
      out_valid <= 1'b0;
      for (int k = 0; k < rmi_pkg::MaxActions; k++) begin
        regret_r[k] <= '0;
        strat_r[k] <= '0;
        sum_r[k] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          rmi_pkg::CFG_NUM_ACTIONS: num_actions_r <= cfg_data;
          rmi_pkg::CFG_OWN_POSITION: own_position_r <= cfg_data[0];
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            kind_r <= in_kind;
            idx_r <= in_action_index;
            val_r <= in_regret_value;
            weighted_r <= in_use_reach;
            reach_r <= (own_position_r ? in_reach_ip : in_reach_oop) > 17'd65536 ?
                       17'd65536 : (own_position_r ? in_reach_ip : in_reach_oop);
            n_r <= n_eff;
            i_r <= '0;
            tot_r <= '0;
            case (in_kind)
              rmi_pkg::KIND_ADD: state_r <= S_ADD;
              rmi_pkg::KIND_ACCUM: state_r <= S_ACC;
              default: state_r <= S_SUM;
            endcase
          end
        end
        S_ADD: begin
          if (idx_r < n_r) begin
            if (reg_add[rmi_pkg::RegW] != reg_add[rmi_pkg::RegW-1])
              regret_r[idx_r[2:0]] <= reg_add[rmi_pkg::RegW] ?
                {1'b1, {(rmi_pkg::RegW-1){1'b0}}} : {1'b0, {(rmi_pkg::RegW-1){1'b1}}};
            else
              regret_r[idx_r[2:0]] <= reg_add[rmi_pkg::RegW-1:0];
          end
          state_r <= S_IDLE;
        end
        S_ACC: begin
          sum_r[i_r] <= sum_add[rmi_pkg::SumW] ? '1 : sum_add[rmi_pkg::SumW-1:0];
          i_r <= i_r + 1'b1;
          if (last_i) state_r <= S_IDLE;
        end
        S_SUM: begin
          tot_r <= tot_r + {4'd0, sel_val};
          i_r <= i_r + 1'b1;
          if (last_i) begin
            i_r <= '0;
            state_r <= S_DIVGO;
          end
        end
        S_DIVGO: begin
          if (tot_r == '0) begin
            if (kind_r == rmi_pkg::KIND_UPDATE) begin
              strat_set_r <= 1'b0;
              state_r <= S_IDLE;
            end else begin
              out_valid <= 1'b1;
              out_out_action <= i_r;
              out_avg_probability <= rmi_pkg::uniform_prob(n_r);
              out_last <= last_i;
              state_r <= S_EMIT;
            end
          end else begin
            state_r <= S_DIVWAIT;
          end
        end
        S_DIVWAIT: begin
          if (div_done) begin
            if (kind_r == rmi_pkg::KIND_UPDATE) begin
              strat_r[i_r] <= div_q;
              i_r <= i_r + 1'b1;
              if (last_i) begin
                strat_set_r <= 1'b1;
                state_r <= S_IDLE;
              end else begin
                state_r <= S_DIVGO;
              end
            end else begin
              out_valid <= 1'b1;
              out_out_action <= i_r;
              out_avg_probability <= div_q;
              out_last <= last_i;
              state_r <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            i_r <= i_r + 1'b1;
            state_r <= last_i ? S_IDLE : S_DIVGO;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_out_only_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_r == S_EMIT) else $error("result outside emit");
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall) else $error("accepting while busy");
  a_div_once: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIVWAIT) else $error("stray divider result");
`endif
endmodule
`default_nettype wire

@@ rtl/rmi_div.sv @@
`default_nettype none
module rmi_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [rmi_pkg::NumW-1:0]    numer,
  input  wire logic [rmi_pkg::TotW-1:0]    denom,
  output logic                             done,
  output logic [rmi_pkg::ProbW-1:0]        quot
);
  // restoring divider; quotient is known to fit 17 bits, so 17 steps
  logic [rmi_pkg::TotW:0] rem_r, rem_nxt;
  logic [rmi_pkg::NumW-1:0] num_r, num_nxt;
  logic [rmi_pkg::ProbW-1:0] q_r, q_nxt;
  logic [rmi_pkg::TotW-1:0] den_r;
  logic [4:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt, done_nxt;
  logic [rmi_pkg::TotW:0] trial;

  always_comb begin
    rem_nxt = rem_r;
    num_nxt = num_r;
    q_nxt = q_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial = {rem_r[rmi_pkg::TotW-1:0], num_r[rmi_pkg::NumW-1]};
    if (start) begin
      // top 51 bits of numerator are below the denominator
      rem_nxt = {2'b0, numer[rmi_pkg::NumW-1:rmi_pkg::ProbW]};
      num_nxt = {numer[rmi_pkg::ProbW-1:0], {(rmi_pkg::NumW-rmi_pkg::ProbW){1'b0}}};
      q_nxt = '0;
      cnt_nxt = 5'd17;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      num_nxt = {num_r[rmi_pkg::NumW-2:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt = {q_r[rmi_pkg::ProbW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[rmi_pkg::ProbW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    num_r <= num_nxt;
    q_r <= q_nxt;
    if (start) den_r <= denom;
  end

  assign quot = q_r;
endmodule
`default_nettype wire
